@@ rtl/rpse_pkg.sv @@
// ----------------------------------------------------------------------------
// rpse_pkg
// Shared types, constants and fixed-point helpers for the RAMP plane stress
// evaluator (signed Q16.16, saturating, round half away from zero).
// ----------------------------------------------------------------------------
package rpse_pkg;

  localparam int W      = 32;          // word width
  localparam int F      = 16;          // fractional bits
  localparam int N      = W + F;       // dividend bits of a fixed-point quotient
  localparam int CNT_W  = $clog2(N);

  typedef logic signed [W-1:0]   word_t;
  typedef logic signed [2*W-1:0] prod_t;
  typedef logic        [2*W-1:0] mag_t;

  localparam word_t WMAX    = {1'b0, {(W-1){1'b1}}};
  localparam word_t WMIN    = {1'b1, {(W-1){1'b0}}};
  localparam word_t FX_ONE  = word_t'(longint'(1) << F);
  localparam word_t FX_HALF = word_t'(longint'(1) << (F - 1));
  localparam mag_t  LIM_NEG = mag_t'(1) << (W - 1);
  localparam mag_t  LIM_POS = LIM_NEG - mag_t'(1);
  localparam mag_t  RND_LSB = mag_t'(1) << (F - 1);

  // register map, word index
  typedef enum logic [2:0] {
    REG_YOUNG       = 3'd0,
    REG_POISSON     = 3'd1,
    REG_PENALTY     = 3'd2,
    REG_DENSITY     = 3'd3,
    REG_REL_DENSITY = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic        [W-2:0] young;
    logic signed [F:0]   nu;
    logic        [W-2:0] q;
    logic        [W-2:0] dens;
    logic        [F:0]   rho;
  } cfg_t;

  // per-configuration coefficients
  typedef struct packed {
    word_t d;
    word_t nud;
    word_t g;
    word_t dp;
    word_t nudp;
    word_t gp;
    word_t dens;
    word_t pm;
  } coef_t;

  typedef enum logic [3:0] {
    CS_DEN, CS_NN, CS_DIV, CS_DIVEND, CS_HALF, CS_D, CS_NUD, CS_G,
    CS_DD, CS_R2LOAD, CS_DP, CS_NUDP, CS_GP, CS_MASS, CS_DONE
  } coef_state_e;

  typedef enum logic [1:0] {
    DV_BASE, DV_R, DV_R2
  } div_sel_e;

  // magnitude plus sign to saturated word
  function automatic word_t settle(input mag_t m, input logic neg);
    word_t r;
    if (neg) begin
      if (m >= LIM_NEG) r = WMIN;
      else              r = -$signed(m[W-1:0]);
    end else begin
      if (m > LIM_POS)  r = WMAX;
      else              r = word_t'(m[W-1:0]);
    end
    return r;
  endfunction

  // round a raw product to F fractional bits and saturate
  function automatic word_t rnd(input prod_t p);
    logic neg;
    mag_t m;
    neg = p[2*W-1];
    m   = neg ? mag_t'(-p) : mag_t'(p);
    m   = m + RND_LSB;
    return settle(m >> F, neg);
  endfunction

  function automatic prod_t mulw(input word_t a, input word_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  function automatic word_t fmul(input word_t a, input word_t b);
    return rnd(mulw(a, b));
  endfunction

  function automatic word_t sadd(input word_t a, input word_t b);
    logic signed [W:0] s;
    word_t r;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) r = s[W] ? WMIN : WMAX;
    else                r = s[W-1:0];
    return r;
  endfunction

  function automatic word_t ssub(input word_t a, input word_t b);
    logic signed [W:0] s;
    word_t r;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) r = s[W] ? WMIN : WMAX;
    else                r = s[W-1:0];
    return r;
  endfunction

  function automatic logic [W-1:0] magn(input word_t a);
    return a[W-1] ? logic'(1'b0) - a : a;
  endfunction

endpackage

@@ rtl/rpse_coef.sv @@
// ----------------------------------------------------------------------------
// rpse_coef
// Sequencer that derives the stiffness coefficients from the registers:
// one multiply per step, a restoring divider one bit per cycle.
// ----------------------------------------------------------------------------
module rpse_coef (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  input  rpse_pkg::cfg_t   cfg_i,
  output logic             busy_o,
  output rpse_pkg::coef_t  coef_o
);

  localparam int W = rpse_pkg::W;
  localparam int F = rpse_pkg::F;
  localparam int N = rpse_pkg::N;

  rpse_pkg::coef_state_e state_q, state_d;
  rpse_pkg::div_sel_e    sel_q;

  rpse_pkg::word_t e_w, nu_w, q_w, dens_w, rho_w;
  rpse_pkg::word_t den_q, base_q, hc_q, r_q, r2_q, dd_q;
  rpse_pkg::word_t d_q, nud_q, g_q, dp_q, nudp_q, gp_q, pm_q;

  // divider
  logic [N-1:0]              num_q;
  logic [W-1:0]              dmag_q;
  logic [W-1:0]              rem_q;
  logic [N-1:0]              quo_q;
  logic [rpse_pkg::CNT_W-1:0] cnt_q;
  logic                      neg_q, dz_q, nz_q, an_q;
  logic                      ld;
  rpse_pkg::word_t           ld_a, ld_b;
  rpse_pkg::div_sel_e        ld_sel;
  logic [W:0]                rs;
  logic                      ge;
  logic                      rup;
  logic [N:0]                qf;
  rpse_pkg::word_t           dres;

  assign e_w    = {1'b0, cfg_i.young};
  assign nu_w   = {{(W-F-1){cfg_i.nu[F]}}, cfg_i.nu};
  assign q_w    = {1'b0, cfg_i.q};
  assign dens_w = {1'b0, cfg_i.dens};
  assign rho_w  = {{(W-F-1){1'b0}}, cfg_i.rho};

  assign rs  = {rem_q, num_q[N-1]};
  assign ge  = rs >= {1'b0, dmag_q};
  assign rup = rem_q >= (dmag_q - rem_q);
  assign qf  = {1'b0, quo_q} + {{N{1'b0}}, rup};

  always_comb begin
    if (dz_q)      dres = nz_q ? '0 : (an_q ? rpse_pkg::WMIN : rpse_pkg::WMAX);
    else           dres = rpse_pkg::settle(rpse_pkg::mag_t'(qf), neg_q);
  end

  // next state and divider launch
  always_comb begin
    state_d = state_q;
    ld      = 1'b0;
    ld_a    = '0;
    ld_b    = '0;
    ld_sel  = rpse_pkg::DV_BASE;
    case (state_q)
      rpse_pkg::CS_DEN:    state_d = rpse_pkg::CS_NN;
      rpse_pkg::CS_NN: begin
        ld      = 1'b1;
        ld_a    = e_w;
        ld_b    = rpse_pkg::ssub(rpse_pkg::FX_ONE, rpse_pkg::fmul(nu_w, nu_w));
        ld_sel  = rpse_pkg::DV_BASE;
        state_d = rpse_pkg::CS_DIV;
      end
      rpse_pkg::CS_DIV: begin
        if (cnt_q == rpse_pkg::CNT_W'(N - 1)) state_d = rpse_pkg::CS_DIVEND;
      end
      rpse_pkg::CS_DIVEND: begin
        case (sel_q)
          rpse_pkg::DV_BASE: state_d = rpse_pkg::CS_HALF;
          rpse_pkg::DV_R:    state_d = rpse_pkg::CS_D;
          default:           state_d = rpse_pkg::CS_DP;
        endcase
      end
      rpse_pkg::CS_HALF: begin
        ld      = 1'b1;
        ld_a    = rho_w;
        ld_b    = den_q;
        ld_sel  = rpse_pkg::DV_R;
        state_d = rpse_pkg::CS_DIV;
      end
      rpse_pkg::CS_D:      state_d = rpse_pkg::CS_NUD;
      rpse_pkg::CS_NUD:    state_d = rpse_pkg::CS_G;
      rpse_pkg::CS_G:      state_d = rpse_pkg::CS_DD;
      rpse_pkg::CS_DD:     state_d = rpse_pkg::CS_R2LOAD;
      rpse_pkg::CS_R2LOAD: begin
        ld      = 1'b1;
        ld_a    = rpse_pkg::sadd(rpse_pkg::FX_ONE, q_w);
        ld_b    = dd_q;
        ld_sel  = rpse_pkg::DV_R2;
        state_d = rpse_pkg::CS_DIV;
      end
      rpse_pkg::CS_DP:     state_d = rpse_pkg::CS_NUDP;
      rpse_pkg::CS_NUDP:   state_d = rpse_pkg::CS_GP;
      rpse_pkg::CS_GP:     state_d = rpse_pkg::CS_MASS;
      rpse_pkg::CS_MASS:   state_d = rpse_pkg::CS_DONE;
      rpse_pkg::CS_DONE:   state_d = rpse_pkg::CS_DONE;
      default:             state_d = rpse_pkg::CS_DEN;
    endcase
    if (restart_i) begin
      state_d = rpse_pkg::CS_DEN;
      ld      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpse_pkg::CS_DEN;
    end else begin
      state_q <= state_d;
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (ld) begin
      sel_q  <= ld_sel;
      num_q  <= {rpse_pkg::magn(ld_a), {F{1'b0}}};
      dmag_q <= rpse_pkg::magn(ld_b);
      rem_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      neg_q  <= ld_a[W-1] ^ ld_b[W-1];
      dz_q   <= (ld_b == '0);
      nz_q   <= (ld_a == '0);
      an_q   <= ld_a[W-1];
    end else if (state_q == rpse_pkg::CS_DIV) begin
      num_q  <= num_q << 1;
      rem_q  <= ge ? W'(rs - {1'b0, dmag_q}) : rs[W-1:0];
      quo_q  <= {quo_q[N-2:0], ge};
      cnt_q  <= cnt_q + 1'b1;
    end
  end

  // coefficient registers, one step per state
  always_ff @(posedge clk_i) begin
    case (state_q)
      rpse_pkg::CS_DEN:
        den_q <= rpse_pkg::sadd(rpse_pkg::FX_ONE,
                 rpse_pkg::fmul(q_w, rpse_pkg::ssub(rpse_pkg::FX_ONE, rho_w)));
      rpse_pkg::CS_DIVEND: begin
        case (sel_q)
          rpse_pkg::DV_BASE: base_q <= dres;
          rpse_pkg::DV_R:    r_q    <= dres;
          default:           r2_q   <= dres;
        endcase
      end
      rpse_pkg::CS_HALF:
        hc_q <= rpse_pkg::fmul(rpse_pkg::FX_HALF, rpse_pkg::ssub(rpse_pkg::FX_ONE, nu_w));
      rpse_pkg::CS_D:    d_q    <= rpse_pkg::fmul(base_q, r_q);
      rpse_pkg::CS_NUD:  nud_q  <= rpse_pkg::fmul(nu_w, d_q);
      rpse_pkg::CS_G:    g_q    <= rpse_pkg::fmul(hc_q, d_q);
      rpse_pkg::CS_DD:   dd_q   <= rpse_pkg::fmul(den_q, den_q);
      rpse_pkg::CS_DP:   dp_q   <= rpse_pkg::fmul(base_q, r2_q);
      rpse_pkg::CS_NUDP: nudp_q <= rpse_pkg::fmul(nu_w, dp_q);
      rpse_pkg::CS_GP:   gp_q   <= rpse_pkg::fmul(hc_q, dp_q);
      rpse_pkg::CS_MASS: pm_q   <= rpse_pkg::fmul(rho_w, dens_w);
      default: ;
    endcase
  end

  assign busy_o      = (state_q != rpse_pkg::CS_DONE);
  assign coef_o.d    = d_q;
  assign coef_o.nud  = nud_q;
  assign coef_o.g    = g_q;
  assign coef_o.dp   = dp_q;
  assign coef_o.nudp = nudp_q;
  assign coef_o.gp   = gp_q;
  assign coef_o.dens = dens_w;
  assign coef_o.pm   = pm_q;

  // a register write always forces a fresh pass
  a_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_i |=> busy_o) else $error("coefficient pass not restarted");

  // divider never runs past its last quotient bit
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rpse_pkg::CS_DIV) |=> (state_q != rpse_pkg::CS_DIV) ||
    (cnt_q != '0)) else $error("divider count wrapped");

endmodule

@@ rtl/ramp_plane_stress_evaluator.sv @@
// ----------------------------------------------------------------------------
// ramp_plane_stress_evaluator
// RAMP-penalized plane stress, its density sensitivity and point mass, one
// quadrature point per cycle while stall_o is low, signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (valid_i / stall_o) carries strain, adjoint and the two
//    scale factors; an item is taken on an edge with valid_i high, stall_o low.
//  - Output channel (valid_o / stall_i) returns one result item per input item.
//  - Registers sit on an APB-style port at byte offsets 0..16, pready is tied
//    high, writes land in the access phase.
//  - The stiffness coefficients depend only on the registers. After reset and
//    after every register write a sequencer rebuilds them (three divisions
//    with a bit-serial divider plus the multiply steps); stall_o is high
//    during that pass.
//  - Per item: six pipeline stages (multiply, round/sum, multiply, round/sum,
//    multiply, round).
//  - Throughput is one item per cycle once the coefficients are ready and the output is not stalled.
//  - A stall on the output freezes the whole pipe: stall_o follows stall_i
//    while the output register is full, nothing is dropped or repeated.
//  - Reset clears all valid bits and starts the coefficient pass.
// ----------------------------------------------------------------------------
module ramp_plane_stress_evaluator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input item
  input  logic        valid_i,
  output logic        stall_o,
  input  logic signed [31:0] strain_xx_i,
  input  logic signed [31:0] strain_yy_i,
  input  logic signed [31:0] strain_xy_i,
  input  logic signed [31:0] stress_scale_i,
  input  logic signed [31:0] adjoint_xx_i,
  input  logic signed [31:0] adjoint_yy_i,
  input  logic signed [31:0] adjoint_xy_i,
  input  logic signed [31:0] mass_scale_i,
  // result item
  output logic        valid_o,
  input  logic        stall_i,
  output logic signed [31:0] stress_xx_o,
  output logic signed [31:0] stress_yy_o,
  output logic signed [31:0] stress_xy_o,
  output logic signed [31:0] stress_sensitivity_o,
  output logic        [30:0] point_mass_o,
  output logic signed [31:0] mass_sensitivity_o
);

  localparam int W = rpse_pkg::W;
  localparam int F = rpse_pkg::F;

  // ---------------- configuration registers ----------------
  rpse_pkg::cfg_t  cfg_q;
  rpse_pkg::coef_t coef;
  logic            cfg_wr;
  logic            busy;
  logic [2:0]      cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.young <= (W-1)'(65536);
      cfg_q.nu    <= (F+1)'(19661);
      cfg_q.q     <= (W-1)'(327680);
      cfg_q.dens  <= (W-1)'(65536);
      cfg_q.rho   <= (F+1)'(62259);
    end else if (cfg_wr) begin
      case (rpse_pkg::reg_idx_e'(cfg_idx))
        rpse_pkg::REG_YOUNG:       cfg_q.young <= pwdata[W-2:0];
        rpse_pkg::REG_POISSON:     cfg_q.nu    <= pwdata[F:0];
        rpse_pkg::REG_PENALTY:     cfg_q.q     <= pwdata[W-2:0];
        rpse_pkg::REG_DENSITY:     cfg_q.dens  <= pwdata[W-2:0];
        rpse_pkg::REG_REL_DENSITY: cfg_q.rho   <= pwdata[F:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (rpse_pkg::reg_idx_e'(cfg_idx))
      rpse_pkg::REG_YOUNG:       prdata = {1'b0, cfg_q.young};
      rpse_pkg::REG_POISSON:     prdata = {{(W-F-1){cfg_q.nu[F]}}, cfg_q.nu};
      rpse_pkg::REG_PENALTY:     prdata = {1'b0, cfg_q.q};
      rpse_pkg::REG_DENSITY:     prdata = {1'b0, cfg_q.dens};
      rpse_pkg::REG_REL_DENSITY: prdata = {{(W-F-1){1'b0}}, cfg_q.rho};
      default:                   prdata = '0;
    endcase
  end

  // coefficients rebuilt after reset and after every write
  rpse_coef u_coef (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_wr),
    .cfg_i     (cfg_q),
    .busy_o    (busy),
    .coef_o    (coef)
  );

  // ---------------- item pipeline ----------------
  // whole pipe advances unless the output register holds an untaken item
  logic en;
  logic in_acc;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  assign en      = !(v6_q && stall_i);
  assign stall_o = busy || !en;
  assign in_acc  = valid_i && !stall_o;

  // stage 1: raw strain products
  rpse_pkg::prod_t p_de0_q, p_nude1_q, p_nude0_q, p_de1_q, p_ge2_q;
  rpse_pkg::prod_t p_dpe0_q, p_nudpe1_q, p_nudpe0_q, p_dpe1_q, p_gpe2_q, p_ms_q;
  rpse_pkg::word_t a1_q, x1_q, y1_q, z1_q;
  // stage 2: rounded stress and derivative stress
  rpse_pkg::word_t s0_2_q, s1_2_q, s2_2_q, t0_q, t1_q, t2_q, ms2_q, a2_q, x2_q, y2_q, z2_q;
  // stage 3: adjoint products
  rpse_pkg::prod_t q0_q, q1_q, q2_q;
  rpse_pkg::word_t s0_3_q, s1_3_q, s2_3_q, ms3_q, a3_q;
  // stage 4: dot product
  rpse_pkg::word_t dot_q, s0_4_q, s1_4_q, s2_4_q, ms4_q, a4_q;
  // stage 5: alpha product
  rpse_pkg::prod_t pa_q;
  rpse_pkg::word_t s0_5_q, s1_5_q, s2_5_q, ms5_q;
  // stage 6: output register
  rpse_pkg::word_t s0_6_q, s1_6_q, s2_6_q, ms6_q, sens_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1
      p_de0_q    <= rpse_pkg::mulw(coef.d,    strain_xx_i);
      p_nude1_q  <= rpse_pkg::mulw(coef.nud,  strain_yy_i);
      p_nude0_q  <= rpse_pkg::mulw(coef.nud,  strain_xx_i);
      p_de1_q    <= rpse_pkg::mulw(coef.d,    strain_yy_i);
      p_ge2_q    <= rpse_pkg::mulw(coef.g,    strain_xy_i);
      p_dpe0_q   <= rpse_pkg::mulw(coef.dp,   strain_xx_i);
      p_nudpe1_q <= rpse_pkg::mulw(coef.nudp, strain_yy_i);
      p_nudpe0_q <= rpse_pkg::mulw(coef.nudp, strain_xx_i);
      p_dpe1_q   <= rpse_pkg::mulw(coef.dp,   strain_yy_i);
      p_gpe2_q   <= rpse_pkg::mulw(coef.gp,   strain_xy_i);
      p_ms_q     <= rpse_pkg::mulw(coef.dens, mass_scale_i);
      a1_q       <= stress_scale_i;
      x1_q       <= adjoint_xx_i;
      y1_q       <= adjoint_yy_i;
      z1_q       <= adjoint_xy_i;
      // stage 2
      s0_2_q <= rpse_pkg::sadd(rpse_pkg::rnd(p_de0_q),  rpse_pkg::rnd(p_nude1_q));
      s1_2_q <= rpse_pkg::sadd(rpse_pkg::rnd(p_nude0_q), rpse_pkg::rnd(p_de1_q));
      s2_2_q <= rpse_pkg::rnd(p_ge2_q);
      t0_q   <= rpse_pkg::sadd(rpse_pkg::rnd(p_dpe0_q),  rpse_pkg::rnd(p_nudpe1_q));
      t1_q   <= rpse_pkg::sadd(rpse_pkg::rnd(p_nudpe0_q), rpse_pkg::rnd(p_dpe1_q));
      t2_q   <= rpse_pkg::rnd(p_gpe2_q);
      ms2_q  <= rpse_pkg::rnd(p_ms_q);
      a2_q   <= a1_q;
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      z2_q   <= z1_q;
      // stage 3
      q0_q   <= rpse_pkg::mulw(t0_q, x2_q);
      q1_q   <= rpse_pkg::mulw(t1_q, y2_q);
      q2_q   <= rpse_pkg::mulw(t2_q, z2_q);
      s0_3_q <= s0_2_q;
      s1_3_q <= s1_2_q;
      s2_3_q <= s2_2_q;
      ms3_q  <= ms2_q;
      a3_q   <= a2_q;
      // stage 4: left-to-right saturating sum
      dot_q  <= rpse_pkg::sadd(rpse_pkg::sadd(rpse_pkg::rnd(q0_q), rpse_pkg::rnd(q1_q)),
                               rpse_pkg::rnd(q2_q));
      s0_4_q <= s0_3_q;
      s1_4_q <= s1_3_q;
      s2_4_q <= s2_3_q;
      ms4_q  <= ms3_q;
      a4_q   <= a3_q;
      // stage 5
      pa_q   <= rpse_pkg::mulw(a4_q, dot_q);
      s0_5_q <= s0_4_q;
      s1_5_q <= s1_4_q;
      s2_5_q <= s2_4_q;
      ms5_q  <= ms4_q;
      // stage 6
      sens_q <= rpse_pkg::rnd(pa_q);
      s0_6_q <= s0_5_q;
      s1_6_q <= s1_5_q;
      s2_6_q <= s2_5_q;
      ms6_q  <= ms5_q;
    end
  end

  assign valid_o              = v6_q;
  assign stress_xx_o          = s0_6_q;
  assign stress_yy_o          = s1_6_q;
  assign stress_xy_o          = s2_6_q;
  assign stress_sensitivity_o = sens_q;
  assign mass_sensitivity_o   = ms6_q;
  // depends on registers only; not held constant while items are in flight
  assign point_mass_o         = coef.pm[W-2:0];

  // no item enters while coefficients are being rebuilt
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_acc) else $error("item accepted during coefficient pass");

  // an accepted item shows up in the first stage
  a_stage1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> v1_q) else $error("accepted item lost at stage one");

  // frozen pipe keeps every valid bit
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable({v1_q, v2_q, v3_q, v4_q, v5_q, v6_q}))
    else $error("pipe moved while stalled");

endmodule
